// ----- rtl/core/rrwc_pkg.sv -----
package rrwc_pkg;

    // Widths of the item fields.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SUM_W   = 16;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned HASH_W  = 2 * SUM_W;

    // Packed stream widths: input tdata holds in_byte then next_first_byte,
    // output tdata holds the checksum then block_index.
    localparam int unsigned S_TDATA_W = 2 * BYTE_W;
    localparam int unsigned M_TDATA_W = HASH_W + COUNT_W;

    // Command codes carried on the input tuser.
    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_ROLL       = 1'b1;

    // Result source codes carried on the output tuser.
    localparam logic SRC_BLOCK = 1'b0;
    localparam logic SRC_ROLL  = 1'b1;

endpackage

// ----- rtl/core/rsync_rolling_weak_checksum.sv -----
// An accepted item sits in the input register; its update is computed in the
// update stage and lands in the result register, from which its result is taken.
// Throughput: one item per cycle while no result is stalled in the result register;
// a roll costs one 16x8 multiply in the update stage.
// Reset is synchronous and active low: the sums, window length, leaving byte,
// block count and all valid flags clear; no clearing pass is needed.
module rsync_rolling_weak_checksum (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rrwc_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] in_byte, [15:8] next_first_byte
    input  logic                            s_axis_tuser,   // [0] command
    input  logic                            s_axis_tlast,   // block_end
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rrwc_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // [31:0] checksum, [63:32] block_index
    output logic                            m_axis_tuser    // [0] from_roll
);

    // Input register.
    logic                          r_in_valid;
    logic                          r_in_cmd;
    logic [rrwc_pkg::BYTE_W-1:0]   r_in_byte;
    logic [rrwc_pkg::BYTE_W-1:0]   r_in_next_first;
    logic                          r_in_last;

    // Checksum state.
    logic [rrwc_pkg::SUM_W-1:0]    r_alpha;
    logic [rrwc_pkg::SUM_W-1:0]    r_beta;
    logic [rrwc_pkg::SUM_W-1:0]    r_len;
    logic [rrwc_pkg::BYTE_W-1:0]   r_leaving;
    logic [rrwc_pkg::COUNT_W-1:0]  r_count;
    logic                          r_in_block;

    // Result register.
    logic                          r_out_valid;
    logic [rrwc_pkg::HASH_W-1:0]   r_out_hash;
    logic [rrwc_pkg::COUNT_W-1:0]  r_out_index;
    logic                          r_out_roll;

    // Next-state values of the update stage.
    logic [rrwc_pkg::SUM_W-1:0]    n_alpha;
    logic [rrwc_pkg::SUM_W-1:0]    n_beta;
    logic [rrwc_pkg::SUM_W-1:0]    n_len;
    logic [rrwc_pkg::BYTE_W-1:0]   n_leaving;
    logic [rrwc_pkg::COUNT_W-1:0]  n_count;
    logic                          n_in_block;
    logic                          n_emit;

    logic [rrwc_pkg::SUM_W-1:0]    base_alpha;
    logic [rrwc_pkg::SUM_W-1:0]    base_beta;
    logic [rrwc_pkg::SUM_W-1:0]    base_len;
    logic [rrwc_pkg::SUM_W-1:0]    leave_prod;
    logic [rrwc_pkg::SUM_W-1:0]    byte_ext;
    logic [rrwc_pkg::SUM_W-1:0]    leave_ext;

    logic out_free;
    logic advance;
    logic in_accept;

    // Handshake: the update stage moves whenever its result has a place to go,
    // or when the item produces no result at all.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (out_free || !n_emit);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_index, r_out_hash};
    assign m_axis_tuser  = r_out_roll;

    // Checksum update for the item held in the input register.
    always_comb begin
        byte_ext   = {{(rrwc_pkg::SUM_W-rrwc_pkg::BYTE_W){1'b0}}, r_in_byte};
        leave_ext  = {{(rrwc_pkg::SUM_W-rrwc_pkg::BYTE_W){1'b0}}, r_leaving};
        // Only the low half of the weighted leaving byte enters beta.
        leave_prod = r_len * leave_ext;
        base_alpha = r_alpha;
        base_beta  = r_beta;
        base_len   = r_len;
        n_alpha    = r_alpha;
        n_beta     = r_beta;
        n_len      = r_len;
        n_leaving  = r_leaving;
        n_count    = r_count;
        n_in_block = r_in_block;
        n_emit     = 1'b0;
        case (r_in_cmd)
            rrwc_pkg::CMD_ACCUMULATE: begin
                // A new block starts from cleared sums with this byte first.
                if (!r_in_block) begin
                    base_alpha = '0;
                    base_beta  = '0;
                    base_len   = '0;
                    n_leaving  = r_in_byte;
                end
                n_alpha = base_alpha + byte_ext;
                n_beta  = base_beta + n_alpha;
                n_len   = base_len + rrwc_pkg::SUM_W'(1);
                if (r_in_last) begin
                    n_emit     = 1'b1;
                    n_count    = r_count + rrwc_pkg::COUNT_W'(1);
                    n_in_block = 1'b0;
                end else begin
                    n_in_block = 1'b1;
                end
            end
            rrwc_pkg::CMD_ROLL: begin
                // Drop the leaving byte, add the entering one.
                n_alpha   = r_alpha - leave_ext + byte_ext;
                n_beta    = r_beta - leave_prod + n_alpha;
                n_leaving = r_in_next_first;
                n_emit    = 1'b1;
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (in_accept) begin
            r_in_cmd        <= s_axis_tuser;
            r_in_byte       <= s_axis_tdata[rrwc_pkg::BYTE_W-1:0];
            r_in_next_first <= s_axis_tdata[rrwc_pkg::S_TDATA_W-1:rrwc_pkg::BYTE_W];
            r_in_last       <= s_axis_tlast;
        end
    end

    // Checksum state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= '0;
            r_beta     <= '0;
            r_len      <= '0;
            r_leaving  <= '0;
            r_count    <= '0;
            r_in_block <= 1'b0;
        end else if (advance) begin
            r_alpha    <= n_alpha;
            r_beta     <= n_beta;
            r_len      <= n_len;
            r_leaving  <= n_leaving;
            r_count    <= n_count;
            r_in_block <= n_in_block;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_emit;
        end
        if (advance && n_emit) begin
            r_out_hash  <= {n_beta, n_alpha};
            r_out_index <= r_count;
            r_out_roll  <= (r_in_cmd == rrwc_pkg::CMD_ROLL) ? rrwc_pkg::SRC_ROLL
                                                             : rrwc_pkg::SRC_BLOCK;
        end
    end

endmodule

// ----- rtl/core/rrwc_checker.sv -----
module rrwc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rrwc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tuser
);

    logic                          out_acc;
    logic [rrwc_pkg::COUNT_W-1:0]  out_index;

    assign out_acc   = m_axis_tvalid && m_axis_tready;
    assign out_index = m_axis_tdata[rrwc_pkg::M_TDATA_W-1:rrwc_pkg::HASH_W];

    // No result is offered right after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // Back-to-back block results carry consecutive indexes.
    a_block_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && (m_axis_tuser == rrwc_pkg::SRC_BLOCK) && $past(i_rst_n)
            && $past(out_acc) && ($past(m_axis_tuser) == rrwc_pkg::SRC_BLOCK))
            |-> (out_index == $past(out_index) + rrwc_pkg::COUNT_W'(1)))
        else $error("block index did not advance by one");

    // A roll result right after a roll result reports the same count.
    a_roll_index_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && (m_axis_tuser == rrwc_pkg::SRC_ROLL) && $past(i_rst_n)
            && $past(out_acc) && ($past(m_axis_tuser) == rrwc_pkg::SRC_ROLL))
            |-> (out_index == $past(out_index)))
        else $error("roll result count changed between rolls");

    // A roll result right after a block result reports the count past that block.
    a_roll_after_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && (m_axis_tuser == rrwc_pkg::SRC_ROLL) && $past(i_rst_n)
            && $past(out_acc) && ($past(m_axis_tuser) == rrwc_pkg::SRC_BLOCK))
            |-> (out_index == $past(out_index) + rrwc_pkg::COUNT_W'(1)))
        else $error("roll result count does not follow the last block");

endmodule

bind rsync_rolling_weak_checksum rrwc_checker u_rrwc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- test/rsync_rolling_weak_checksum_checker.sv -----
`timescale 1ns / 1ps

module rsync_rolling_weak_checksum_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream as seen at the block.
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [rrwc_pkg::S_TDATA_W-1:0]  i_s_tdata,   // [7:0] in_byte, [15:8] next_first_byte
    input  logic                            i_s_tuser,   // [0] command
    input  logic                            i_s_tlast,   // block_end
    // Result stream as seen at the block.
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [rrwc_pkg::M_TDATA_W-1:0]  i_m_tdata,   // [31:0] checksum, [63:32] block_index
    input  logic                            i_m_tuser,   // [0] from_roll
    output int                              o_fail_count,
    output int                              o_pending
);

    typedef struct packed {
        logic [rrwc_pkg::HASH_W-1:0]  checksum;
        logic [rrwc_pkg::COUNT_W-1:0] block_index;
        logic                         from_roll;
    } t_result;

    // Shadow copy of the checksum state.
    logic [rrwc_pkg::SUM_W-1:0]   alpha_q;
    logic [rrwc_pkg::SUM_W-1:0]   beta_q;
    logic [rrwc_pkg::SUM_W-1:0]   length_q;
    logic [rrwc_pkg::BYTE_W-1:0]  first_byte_q;
    logic [rrwc_pkg::COUNT_W-1:0] block_count_q;
    logic                         block_open_q;

    t_result hash_queue[$];
    int      mismatch_count = 0;

    // Advance the shadow state by one item and report the result it emits, if any.
    task automatic step_checksum(input logic cmd, input logic [rrwc_pkg::BYTE_W-1:0] in_byte,
                                 input logic [rrwc_pkg::BYTE_W-1:0] next_first,
                                 input logic last,
                                 output logic emitted, output t_result res);
        logic [rrwc_pkg::SUM_W-1:0] weighted;
        logic [rrwc_pkg::SUM_W-1:0] in_ext;
        logic [rrwc_pkg::SUM_W-1:0] first_ext;
        begin
            emitted = 1'b0;
            res     = '0;
            in_ext  = rrwc_pkg::SUM_W'(in_byte);
            if (cmd == rrwc_pkg::CMD_ACCUMULATE) begin
                // The first byte of a block restarts the sums.
                if (!block_open_q) begin
                    alpha_q      = '0;
                    beta_q       = '0;
                    length_q     = '0;
                    first_byte_q = in_byte;
                    block_open_q = 1'b1;
                end
                alpha_q  = alpha_q + in_ext;
                beta_q   = beta_q + alpha_q;
                length_q = length_q + rrwc_pkg::SUM_W'(1);
                if (last) begin
                    emitted         = 1'b1;
                    res.checksum    = {beta_q, alpha_q};
                    res.block_index = block_count_q;
                    res.from_roll   = rrwc_pkg::SRC_BLOCK;
                    block_count_q   = block_count_q + rrwc_pkg::COUNT_W'(1);
                    block_open_q    = 1'b0;
                end
            end else begin
                // Slide the window: the remembered first byte leaves, in_byte enters.
                first_ext       = rrwc_pkg::SUM_W'(first_byte_q);
                weighted        = length_q * first_ext;
                alpha_q         = alpha_q - first_ext + in_ext;
                beta_q          = beta_q - weighted + alpha_q;
                first_byte_q    = next_first;
                emitted         = 1'b1;
                res.checksum    = {beta_q, alpha_q};
                res.block_index = block_count_q;
                res.from_roll   = rrwc_pkg::SRC_ROLL;
            end
        end
    endtask

    // Compare results first, then predict from the item accepted at the same edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result fresh;
        logic    emitted;
        if (!i_rst_n) begin
            alpha_q       = '0;
            beta_q        = '0;
            length_q      = '0;
            first_byte_q  = '0;
            block_count_q = '0;
            block_open_q  = 1'b0;
            hash_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.checksum    = i_m_tdata[rrwc_pkg::HASH_W-1:0];
                got.block_index = i_m_tdata[rrwc_pkg::HASH_W +: rrwc_pkg::COUNT_W];
                got.from_roll   = i_m_tuser;
                if (hash_queue.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected result sum=%h index=%h roll=%b",
                                 $realtime, got.checksum, got.block_index, got.from_roll);
                    mismatch_count++;
                end else begin
                    want = hash_queue.pop_front();
                    if (got.checksum !== want.checksum ||
                        got.block_index !== want.block_index ||
                        got.from_roll !== want.from_roll) begin
                        if (mismatch_count < 10)
                            $display("%0t: sum %h/%h index %h/%h roll %b/%b (exp/got)",
                                     $realtime, want.checksum, got.checksum,
                                     want.block_index, got.block_index,
                                     want.from_roll, got.from_roll);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                step_checksum(i_s_tuser, i_s_tdata[rrwc_pkg::BYTE_W-1:0],
                              i_s_tdata[rrwc_pkg::BYTE_W +: rrwc_pkg::BYTE_W],
                              i_s_tlast, emitted, fresh);
                if (emitted)
                    hash_queue.push_back(fresh);
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= hash_queue.size();
    end

endmodule

// ----- test/rsync_rolling_weak_checksum_tb.sv -----
`timescale 1ns / 1ps

module rsync_rolling_weak_checksum_tb;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [rrwc_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;    // [7:0] in_byte, [15:8] next_first_byte
    logic                            s_axis_tuser = 1'b0;  // [0] command
    logic                            s_axis_tlast = 1'b0;  // block_end
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [rrwc_pkg::M_TDATA_W-1:0]  m_axis_tdata;         // [31:0] checksum, [63:32] block_index
    logic                            m_axis_tuser;         // [0] from_roll

    int   fail_count;
    int   pending;
    int   items_sent = 0;
    logic src_idle_on = 1'b1;
    logic sink_idle_on = 1'b1;
    int   sink_hold = 0;

    rsync_rolling_weak_checksum dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rsync_rolling_weak_checksum_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    // Result side: alternate stall bursts with runs of readiness.
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
        end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            sink_hold = $urandom_range(0, 14);
        end else begin
            m_axis_tready <= 1'b1;
            sink_hold = $urandom_range(0, 7);
        end
    end

    // Bytes lean toward the extremes so the sums wrap often.
    function automatic logic [rrwc_pkg::BYTE_W-1:0] pick_byte();
        int sel;
        begin
            sel = $urandom_range(0, 7);
            if (sel == 0)
                return 8'h00;
            else if (sel == 1)
                return 8'hFF;
            else
                return 8'($urandom_range(0, 255));
        end
    endfunction

    // Present one item, with an optional gap in front, and wait for its acceptance.
    task automatic send_item(input logic cmd, input logic [rrwc_pkg::BYTE_W-1:0] in_byte,
                             input logic [rrwc_pkg::BYTE_W-1:0] next_first, input logic last);
        begin
            if (src_idle_on && $urandom_range(0, 3) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {next_first, in_byte};
            s_axis_tuser  <= cmd;
            s_axis_tlast  <= last;
            do @(posedge i_clk); while (!s_axis_tready);
            items_sent++;
        end
    endtask

    task automatic send_block(input int len);
        begin
            for (int k = 0; k < len; k++)
                send_item(rrwc_pkg::CMD_ACCUMULATE, pick_byte(), 8'($urandom_range(0, 255)),
                          k == len - 1);
        end
    endtask

    task automatic send_rolls(input int count);
        begin
            for (int k = 0; k < count; k++)
                send_item(rrwc_pkg::CMD_ROLL, pick_byte(), pick_byte(),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int  kind;
        int  len;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Rolls on the zero state straight after reset.
        send_item(rrwc_pkg::CMD_ROLL, 8'hFF, 8'hAB, 1'b0);
        send_item(rrwc_pkg::CMD_ROLL, 8'h00, 8'h00, 1'b1);
        // Single-byte blocks at both extremes.
        send_item(rrwc_pkg::CMD_ACCUMULATE, 8'hFF, 8'h00, 1'b1);
        send_item(rrwc_pkg::CMD_ACCUMULATE, 8'h00, 8'hFF, 1'b1);
        // A block of all-ones bytes.
        send_item(rrwc_pkg::CMD_ACCUMULATE, 8'hFF, 8'hFF, 1'b0);
        send_item(rrwc_pkg::CMD_ACCUMULATE, 8'hFF, 8'hFF, 1'b0);
        send_item(rrwc_pkg::CMD_ACCUMULATE, 8'hFF, 8'hFF, 1'b0);
        send_item(rrwc_pkg::CMD_ACCUMULATE, 8'hFF, 8'hFF, 1'b1);
        // A roll in the middle of a block, which then continues.
        send_item(rrwc_pkg::CMD_ACCUMULATE, 8'h01, 8'h00, 1'b0);
        send_item(rrwc_pkg::CMD_ACCUMULATE, 8'h80, 8'h00, 1'b0);
        send_item(rrwc_pkg::CMD_ROLL, 8'h55, 8'hAA, 1'b1);
        send_item(rrwc_pkg::CMD_ACCUMULATE, 8'h7F, 8'h00, 1'b1);
        // Rolls over the last block, then a block of 00 and FF.
        send_item(rrwc_pkg::CMD_ROLL, 8'hFF, 8'h00, 1'b0);
        send_item(rrwc_pkg::CMD_ROLL, 8'h00, 8'hFF, 1'b1);
        send_item(rrwc_pkg::CMD_ROLL, 8'hA5, 8'h5A, 1'b0);
        send_item(rrwc_pkg::CMD_ROLL, 8'hFF, 8'hFF, 1'b1);
        send_item(rrwc_pkg::CMD_ACCUMULATE, 8'h00, 8'h00, 1'b0);
        send_item(rrwc_pkg::CMD_ACCUMULATE, 8'hFF, 8'h00, 1'b1);

        // Random sequences, mostly well-formed blocks and roll runs.
        while (items_sent < 700) begin
            if (items_sent >= 600) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end else begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64)
                                                  : $urandom_range(1, 12);
                send_block(len);
                send_rolls($urandom_range(0, 4));
            end else if (kind <= 7) begin
                len = $urandom_range(2, 10);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 3) == 0)
                        send_rolls(1);
                    send_item(rrwc_pkg::CMD_ACCUMULATE, pick_byte(),
                              8'($urandom_range(0, 255)), k == len - 1);
                end
            end else if (kind == 8) begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                send_rolls($urandom_range(1, 10));
            end
        end

        // Drain outstanding results, then allow for the pipeline.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("rsync_rolling_weak_checksum test passed");
        else
            $display("rsync_rolling_weak_checksum test failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4000000;
        $display("rsync_rolling_weak_checksum test failed");
        $finish;
    end

endmodule
